// ----- hdl/epg_pkg.sv -----
package epg_pkg;

	localparam int MAX_EDGES_DEF = 65536;
	localparam int TAYLOR_TERMS = 24;

	localparam logic [63:0] ONE62 = 64'h4000_0000_0000_0000;
	localparam logic [63:0] ONE32 = 64'h0000_0001_0000_0000;
	localparam logic [63:0] LN2_Q32 = 64'd2977044472;
	localparam logic [63:0] X_LIMIT = 64'd63 * LN2_Q32;
	localparam logic [63:0] INT64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] INT64_MIN = 64'h8000_0000_0000_0000;
	localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
	localparam logic [16:0] W_ONE = 17'd65536;

	localparam logic [2:0] REG_DECAY = 3'd0;
	localparam logic [2:0] REG_AMP = 3'd1;
	localparam logic [2:0] REG_WEIGHT = 3'd2;
	localparam logic [2:0] REG_COUNT = 3'd3;

	localparam logic [31:0] DECAY_RST = 32'd65536;
	localparam logic [31:0] AMP_RST = 32'd65536;
	localparam logic [16:0] WEIGHT_RST = 17'd32768;
	localparam logic [16:0] COUNT_RST = 17'd0;

	// floor((2^64-1)/k) for the taylor divisors
	localparam logic [63:0] RECIP [32] = '{
		ALL_ONES,
		ALL_ONES / 64'd1, ALL_ONES / 64'd2, ALL_ONES / 64'd3, ALL_ONES / 64'd4,
		ALL_ONES / 64'd5, ALL_ONES / 64'd6, ALL_ONES / 64'd7, ALL_ONES / 64'd8,
		ALL_ONES / 64'd9, ALL_ONES / 64'd10, ALL_ONES / 64'd11, ALL_ONES / 64'd12,
		ALL_ONES / 64'd13, ALL_ONES / 64'd14, ALL_ONES / 64'd15, ALL_ONES / 64'd16,
		ALL_ONES / 64'd17, ALL_ONES / 64'd18, ALL_ONES / 64'd19, ALL_ONES / 64'd20,
		ALL_ONES / 64'd21, ALL_ONES / 64'd22, ALL_ONES / 64'd23, ALL_ONES / 64'd24,
		ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES
	};

	typedef struct packed {
		logic        func;
		logic        err;
		logic [16:0] idx;
		logic [31:0] len;
	} ent_t;

	typedef struct packed {
		logic valid;
		ent_t ent;
	} qhead_t;

	typedef struct packed {
		logic [31:0] kappa;
		logic [31:0] amp;
		logic [16:0] w;
	} cfg_t;

	typedef struct packed {
		logic        start;
		logic [63:0] a;
		logic [63:0] b;
	} mul_req_t;

	typedef struct packed {
		logic         done;
		logic [127:0] prod;
	} mul_rsp_t;

	typedef struct packed {
		logic        start;
		logic [63:0] num;
		logic [63:0] den;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [63:0] quo;
	} div_rsp_t;

endpackage

// ----- hdl/epg_ifs.sv -----
interface epg_item_if;
	logic        valid;
	logic        ready;
	logic        func;
	logic [16:0] edge_index;
	logic [31:0] edge_length;
	modport source(output valid, func, edge_index, edge_length, input ready);
	modport sink(input valid, func, edge_index, edge_length, output ready);
endinterface

interface epg_triplet_if;
	logic               valid;
	logic               ready;
	logic [17:0]        row;
	logic [17:0]        col;
	logic signed [63:0] value;
	logic               last;
	logic               index_error;
	modport source(output valid, row, col, value, last, index_error, input ready);
	modport sink(input valid, row, col, value, last, index_error, output ready);
endinterface

interface epg_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [31:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

// ----- hdl/edge_precision_triplet_gen.sv -----
// edge items: four triplets stream out after the exp, square and two divides; stationary
// items give one triplet after the scale products, index errors one cleared triplet
// throughput: the back end works on one item at a time, set by the shared multiplier
// (taylor exp takes 24 rounds) and the one-bit divider (two divides per edge item)
// a 2-entry queue takes new requests while the back end works
// arst_n clears queue, sequencer and output valid; registers return to their defaults
module edge_precision_triplet_gen #(
	parameter int MAX_EDGES = epg_pkg::MAX_EDGES_DEF
) (
	input logic             clk,
	input logic             arst_n,
	epg_cfg_if.sink         cfg,
	epg_item_if.sink        item,
	epg_triplet_if.source   triplet
);
	epg_pkg::cfg_t     cfg_q;
	logic [16:0]       edge_count_q;
	epg_pkg::qhead_t   head;
	logic              pop;
	epg_pkg::mul_req_t mul_req;
	epg_pkg::mul_rsp_t mul_rsp;
	epg_pkg::div_req_t div_req;
	epg_pkg::div_rsp_t div_rsp;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.kappa <= epg_pkg::DECAY_RST;
			cfg_q.amp <= epg_pkg::AMP_RST;
			cfg_q.w <= epg_pkg::WEIGHT_RST;
			edge_count_q <= epg_pkg::COUNT_RST;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				epg_pkg::REG_DECAY: cfg_q.kappa <= cfg.data;
				epg_pkg::REG_AMP: cfg_q.amp <= cfg.data;
				epg_pkg::REG_WEIGHT: cfg_q.w <= cfg.data[16:0];
				epg_pkg::REG_COUNT: edge_count_q <= cfg.data[16:0];
				default: ;
			endcase
		end
	end

	epg_front #(.MAX_EDGES(MAX_EDGES)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (item),
		.edge_count (edge_count_q),
		.head       (head),
		.pop        (pop)
	);

	epg_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mul_req),
		.rsp    (mul_rsp)
	);

	epg_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	epg_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.head    (head),
		.pop     (pop),
		.mul_req (mul_req),
		.mul_rsp (mul_rsp),
		.div_req (div_req),
		.div_rsp (div_rsp),
		.triplet (triplet)
	);

endmodule

// ----- hdl/epg_front.sv -----
module epg_front #(
	parameter int MAX_EDGES = epg_pkg::MAX_EDGES_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	epg_item_if.sink        item,
	input  logic [16:0]     edge_count,
	output epg_pkg::qhead_t head,
	input  logic            pop
);
	localparam int QDEPTH = 2;
	localparam int PW = $clog2(QDEPTH);
	localparam logic [16:0] MAX_E = 17'(MAX_EDGES);

	epg_pkg::ent_t fifo_q [QDEPTH];
	logic [PW-1:0] wp_q, rp_q;
	logic [PW:0]   cnt_q;
	logic [16:0]   bound;
	logic          push;
	epg_pkg::ent_t ent_in;

	always_comb begin
		bound = (edge_count < MAX_E) ? edge_count : MAX_E;
		ent_in.func = item.func;
		ent_in.idx = item.edge_index;
		ent_in.len = item.edge_length;
		ent_in.err = (item.edge_index == 17'd0) || (item.edge_index > bound);
		item.ready = (cnt_q != (PW+1)'(QDEPTH));
		push = item.valid && item.ready;
		head.valid = (cnt_q != '0);
		head.ent = fifo_q[rp_q];
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wp_q] <= ent_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= wp_q + 1'b1;
			end
			if (pop) begin
				rp_q <= rp_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ----- hdl/epg_mul.sv -----
module epg_mul (
	input  logic              clk,
	input  logic              arst_n,
	input  epg_pkg::mul_req_t req,
	output epg_pkg::mul_rsp_t rsp
);
	logic [63:0]  a_q, b_q;
	logic [127:0] acc_q;
	logic [1:0]   cnt_q;
	logic         busy_q, done_q;
	logic [31:0]  pa, pb;
	logic [63:0]  part;
	logic [127:0] addend;

	always_comb begin
		case (cnt_q)
			2'd0: begin
				pa = a_q[31:0];
				pb = b_q[31:0];
				addend = 128'd0;
			end
			2'd1: begin
				pa = a_q[31:0];
				pb = b_q[63:32];
				addend = 128'd0;
			end
			2'd2: begin
				pa = a_q[63:32];
				pb = b_q[31:0];
				addend = 128'd0;
			end
			default: begin
				pa = a_q[63:32];
				pb = b_q[63:32];
				addend = 128'd0;
			end
		endcase
		part = 64'(pa) * 64'(pb);
		case (cnt_q)
			2'd0: addend = {64'd0, part};
			2'd1, 2'd2: addend = {32'd0, part, 32'd0};
			default: addend = {part, 64'd0};
		endcase
		rsp.done = done_q;
		rsp.prod = acc_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
			acc_q <= '0;
			a_q <= '0;
			b_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				a_q <= req.a;
				b_q <= req.b;
				acc_q <= '0;
				cnt_q <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				acc_q <= acc_q + addend;
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == 2'd3) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

// ----- hdl/epg_div.sv -----
module epg_div (
	input  logic              clk,
	input  logic              arst_n,
	input  epg_pkg::div_req_t req,
	output epg_pkg::div_rsp_t rsp
);
	logic [63:0] rem_q, sh_q, q_q, den_q;
	logic [5:0]  cnt_q;
	logic        busy_q, done_q;
	logic [64:0] t;
	logic        ge;

	always_comb begin
		t = {rem_q, sh_q[63]};
		ge = (t >= {1'b0, den_q});
		rsp.done = done_q;
		rsp.quo = q_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
			rem_q <= '0;
			sh_q <= '0;
			q_q <= '0;
			den_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				if ((req.den == 64'd0) || ({32'd0, req.num[63:32]} >= req.den)) begin
					q_q <= epg_pkg::ALL_ONES;
					done_q <= 1'b1;
				end else begin
					rem_q <= {32'd0, req.num[63:32]};
					sh_q <= {req.num[31:0], 32'd0};
					den_q <= req.den;
					q_q <= '0;
					cnt_q <= '0;
					busy_q <= 1'b1;
				end
			end else if (busy_q) begin
				rem_q <= ge ? 64'(t - {1'b0, den_q}) : t[63:0];
				q_q <= {q_q[62:0], ge};
				sh_q <= {sh_q[62:0], 1'b0};
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == 6'd63) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

// ----- hdl/epg_back.sv -----
module epg_back (
	input  logic              clk,
	input  logic              arst_n,
	input  epg_pkg::cfg_t     cfg,
	input  epg_pkg::qhead_t   head,
	output logic              pop,
	output epg_pkg::mul_req_t mul_req,
	input  epg_pkg::mul_rsp_t mul_rsp,
	output epg_pkg::div_req_t div_req,
	input  epg_pkg::div_rsp_t div_rsp,
	epg_triplet_if.source     triplet
);
	typedef enum logic [3:0] {
		S_IDLE, S_TAU, S_SCALE, S_STAT, S_X, S_RED, S_TMUL, S_TREC,
		S_TFIX, S_D2, S_DIVA, S_DIVB, S_UP, S_LO, S_OFF, S_EMIT
	} state_t;

	state_t        state_q;
	epg_pkg::ent_t ent_q;
	logic          mpend_q, dpend_q;
	logic [63:0]   tau2_q, scale_q, xr_q, term_q, q0_q, sum_q;
	logic [63:0]   d_q, d2_q, a_q, b_q, up_q, lo_q, off_q;
	logic [5:0]    n_q;
	logic [2:0]    j_q;
	logic [4:0]    k_q;
	logic [1:0]    ecnt_q;
	logic          ov_q, olast_q, oerr_q;
	logic [17:0]   orow_q, ocol_q;
	logic [63:0]   oval_q;

	logic [16:0] w_c;
	logic [63:0] w32, omw32, den, lim, q0k, trem, qf, sum_n;
	logic [17:0] hd, tl;
	logic        mul_st, can_load;

	function automatic logic [63:0] sat_add(input logic [63:0] x, input logic [63:0] y);
		logic [64:0] s;
		s = {1'b0, x} + {1'b0, y};
		return s[64] ? epg_pkg::ALL_ONES : s[63:0];
	endfunction

	function automatic logic [63:0] sh62(input logic [127:0] p);
		return (p[127:126] != 2'd0) ? epg_pkg::ALL_ONES : p[125:62];
	endfunction

	function automatic logic [63:0] sh32(input logic [127:0] p);
		return (p[127:96] != 32'd0) ? epg_pkg::ALL_ONES : p[95:32];
	endfunction

	function automatic logic [63:0] sh16(input logic [127:0] p);
		return (p[127:80] != 48'd0) ? epg_pkg::ALL_ONES : p[79:16];
	endfunction

	function automatic logic [63:0] pos_val(input logic [63:0] m);
		return (m > epg_pkg::INT64_MAX) ? epg_pkg::INT64_MAX : m;
	endfunction

	function automatic logic [63:0] neg_val(input logic [63:0] m);
		return m[63] ? epg_pkg::INT64_MIN : 64'((~m) + 64'd1);
	endfunction

	always_comb begin
		w_c = (cfg.w > epg_pkg::W_ONE) ? epg_pkg::W_ONE : cfg.w;
		w32 = {31'd0, w_c, 16'd0};
		omw32 = epg_pkg::ONE32 - w32;
		den = epg_pkg::ONE62 - d2_q;
		hd = {ent_q.idx, 1'b0};
		tl = hd - 18'd1;
		lim = epg_pkg::LN2_Q32 << j_q;
		q0k = 64'(q0_q * 64'(k_q));
		trem = term_q - q0k;
		qf = (trem >= 64'(k_q)) ? q0_q + 64'd1 : q0_q;
		sum_n = k_q[0] ? sum_q - qf : sum_q + qf;
		can_load = !ov_q || triplet.ready;
		pop = (state_q == S_IDLE) && head.valid;

		mul_st = 1'b1;
		mul_req.a = '0;
		mul_req.b = '0;
		case (state_q)
			S_TAU: begin
				mul_req.a = {32'd0, cfg.amp};
				mul_req.b = {32'd0, cfg.amp};
			end
			S_SCALE: begin
				mul_req.a = {31'd0, cfg.kappa, 1'b0};
				mul_req.b = tau2_q;
			end
			S_STAT: begin
				mul_req.a = scale_q;
				mul_req.b = omw32;
			end
			S_X: begin
				mul_req.a = {32'd0, cfg.kappa};
				mul_req.b = {32'd0, ent_q.len};
			end
			S_TMUL: begin
				mul_req.a = term_q;
				mul_req.b = {2'd0, xr_q[31:0], 30'd0};
			end
			S_TREC: begin
				mul_req.a = term_q;
				mul_req.b = epg_pkg::RECIP[k_q];
			end
			S_D2: begin
				mul_req.a = d_q;
				mul_req.b = d_q;
			end
			S_UP: begin
				mul_req.a = scale_q;
				mul_req.b = sat_add(w32, a_q);
			end
			S_LO: begin
				mul_req.a = scale_q;
				mul_req.b = sat_add(omw32, a_q);
			end
			S_OFF: begin
				mul_req.a = scale_q;
				mul_req.b = b_q;
			end
			default: mul_st = 1'b0;
		endcase
		mul_req.start = mul_st && !mpend_q;

		div_req.start = ((state_q == S_DIVA) || (state_q == S_DIVB)) && !dpend_q;
		div_req.num = (state_q == S_DIVA) ? d2_q : d_q;
		div_req.den = den;

		triplet.valid = ov_q;
		triplet.row = orow_q;
		triplet.col = ocol_q;
		triplet.value = $signed(oval_q);
		triplet.last = olast_q;
		triplet.index_error = oerr_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ent_q <= '0;
			mpend_q <= 1'b0;
			dpend_q <= 1'b0;
			tau2_q <= '0;
			scale_q <= '0;
			xr_q <= '0;
			term_q <= '0;
			q0_q <= '0;
			sum_q <= '0;
			d_q <= '0;
			d2_q <= '0;
			a_q <= '0;
			b_q <= '0;
			up_q <= '0;
			lo_q <= '0;
			off_q <= '0;
			n_q <= '0;
			j_q <= '0;
			k_q <= '0;
			ecnt_q <= '0;
			ov_q <= 1'b0;
			orow_q <= '0;
			ocol_q <= '0;
			oval_q <= '0;
			olast_q <= 1'b0;
			oerr_q <= 1'b0;
		end else begin
			if (triplet.ready) begin
				ov_q <= 1'b0;
			end
			if (mul_req.start) begin
				mpend_q <= 1'b1;
			end
			if (div_req.start) begin
				dpend_q <= 1'b1;
			end
			if (mul_rsp.done) begin
				mpend_q <= 1'b0;
			end
			if (div_rsp.done) begin
				dpend_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (head.valid) begin
						ent_q <= head.ent;
						ecnt_q <= '0;
						state_q <= head.ent.err ? S_EMIT : S_TAU;
					end
				end
				S_TAU: begin
					if (mul_rsp.done) begin
						tau2_q <= mul_rsp.prod[63:0];
						state_q <= S_SCALE;
					end
				end
				S_SCALE: begin
					if (mul_rsp.done) begin
						scale_q <= sh16(mul_rsp.prod);
						state_q <= ent_q.func ? S_STAT : S_X;
					end
				end
				S_STAT: begin
					if (mul_rsp.done) begin
						up_q <= pos_val(sh32(mul_rsp.prod));
						state_q <= S_EMIT;
					end
				end
				S_X: begin
					if (mul_rsp.done) begin
						xr_q <= mul_rsp.prod[63:0];
						n_q <= '0;
						j_q <= 3'd5;
						if (mul_rsp.prod[63:0] >= epg_pkg::X_LIMIT) begin
							d_q <= '0;
							state_q <= S_D2;
						end else begin
							state_q <= S_RED;
						end
					end
				end
				S_RED: begin
					if (xr_q >= lim) begin
						xr_q <= xr_q - lim;
						n_q[j_q] <= 1'b1;
					end
					j_q <= j_q - 3'd1;
					if (j_q == 3'd0) begin
						term_q <= epg_pkg::ONE62;
						sum_q <= epg_pkg::ONE62;
						k_q <= 5'd1;
						state_q <= S_TMUL;
					end
				end
				S_TMUL: begin
					if (mul_rsp.done) begin
						term_q <= sh62(mul_rsp.prod);
						state_q <= S_TREC;
					end
				end
				S_TREC: begin
					if (mul_rsp.done) begin
						q0_q <= mul_rsp.prod[127:64];
						state_q <= S_TFIX;
					end
				end
				S_TFIX: begin
					term_q <= qf;
					sum_q <= sum_n;
					k_q <= k_q + 5'd1;
					if (k_q == 5'(epg_pkg::TAYLOR_TERMS)) begin
						d_q <= sum_n >> n_q;
						state_q <= S_D2;
					end else begin
						state_q <= S_TMUL;
					end
				end
				S_D2: begin
					if (mul_rsp.done) begin
						d2_q <= sh62(mul_rsp.prod);
						state_q <= S_DIVA;
					end
				end
				S_DIVA: begin
					if (div_rsp.done) begin
						a_q <= div_rsp.quo;
						state_q <= S_DIVB;
					end
				end
				S_DIVB: begin
					if (div_rsp.done) begin
						b_q <= div_rsp.quo;
						state_q <= S_UP;
					end
				end
				S_UP: begin
					if (mul_rsp.done) begin
						up_q <= pos_val(sh32(mul_rsp.prod));
						state_q <= S_LO;
					end
				end
				S_LO: begin
					if (mul_rsp.done) begin
						lo_q <= pos_val(sh32(mul_rsp.prod));
						state_q <= S_OFF;
					end
				end
				S_OFF: begin
					if (mul_rsp.done) begin
						off_q <= neg_val(sh32(mul_rsp.prod));
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (can_load) begin
						ov_q <= 1'b1;
						oerr_q <= ent_q.err;
						ecnt_q <= ecnt_q + 2'd1;
						if (ent_q.err) begin
							orow_q <= '0;
							ocol_q <= '0;
							oval_q <= '0;
							olast_q <= 1'b1;
							state_q <= S_IDLE;
						end else if (ent_q.func) begin
							orow_q <= tl;
							ocol_q <= tl;
							oval_q <= up_q;
							olast_q <= 1'b1;
							state_q <= S_IDLE;
						end else begin
							case (ecnt_q)
								2'd0: begin
									orow_q <= tl;
									ocol_q <= tl;
									oval_q <= up_q;
									olast_q <= 1'b0;
								end
								2'd1: begin
									orow_q <= hd;
									ocol_q <= hd;
									oval_q <= lo_q;
									olast_q <= 1'b0;
								end
								2'd2: begin
									orow_q <= tl;
									ocol_q <= hd;
									oval_q <= off_q;
									olast_q <= 1'b0;
								end
								default: begin
									orow_q <= hd;
									ocol_q <= tl;
									oval_q <= off_q;
									olast_q <= 1'b1;
									state_q <= S_IDLE;
								end
							endcase
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_mul_pend: assert property (@(posedge clk) disable iff (!arst_n)
		mul_rsp.done |-> mpend_q)
		else $error("multiplier result without a pending request");

	a_div_pend: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> dpend_q)
		else $error("divider result without a pending request");

	a_red_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_TMUL) |-> (xr_q < epg_pkg::LN2_Q32))
		else $error("range reduction left a remainder above ln2");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(ov_q && oerr_q) |-> (oval_q == 64'd0) && olast_q && (orow_q == 18'd0))
		else $error("index error result not cleared");

endmodule
